@@ rtl/tw_pkg.sv @@
// shared types, constants and round helpers for the wide tea-style cipher
// no dependencies; imported by tw_key_regs, tw_half_round and the top level
package tw_pkg;

    localparam int ITERATIONS  = 64;
    localparam int HALF_ROUNDS = 2 * ITERATIONS;
    localparam int WORD_W      = 64;
    localparam int CFG_IDX_W   = 4;
    localparam int SHL         = 14;
    localparam int SHR         = 15;

    localparam logic [WORD_W-1:0] DELTA = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = CFG_IDX_W'(3);

    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } key_t;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } blk_t;

    // per-stage constants: which half of the iteration and the sum it uses
    typedef struct packed {
        logic              odd;
        logic [WORD_W-1:0] enc_sum;
        logic [WORD_W-1:0] dec_sum;
    } stage_cfg_t;

    function automatic logic [WORD_W-1:0] mix(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] s,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        mix = ((x << SHL) + ka) ^ (x + s) ^ ((x >> SHR) + kb);
    endfunction

    // evaluated at elaboration only, stage index is a constant
    function automatic stage_cfg_t stage_cfg(input int stage);
        stage_cfg_t c;
        int         n;
        n         = stage >> 1;
        c.odd     = 1'(stage & 1);
        c.enc_sum = WORD_W'(n + 1) * DELTA;
        c.dec_sum = WORD_W'(ITERATIONS - n) * DELTA;
        return c;
    endfunction

endpackage

@@ rtl/tw_key_regs.sv @@
// key register bank written through the configuration request channel
// depends on tw_pkg
module tw_key_regs
    import tw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output key_t                 key
);

    key_t key_reg;
    key_t key_next;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KEY_WORD0: key_next.k0 = cfg_data;
                REG_KEY_WORD1: key_next.k1 = cfg_data;
                REG_KEY_WORD2: key_next.k2 = cfg_data;
                REG_KEY_WORD3: key_next.k3 = cfg_data;
                default:       key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

endmodule

@@ rtl/tw_half_round.sv @@
// one registered half-round of the feistel network, encrypt or decrypt per item
// depends on tw_pkg (mix function, block and key types)
module tw_half_round
    import tw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  stage_cfg_t cfg,
    input  key_t       key,
    input  logic       valid_in,
    input  blk_t       blk_in,
    output logic       valid_out,
    output blk_t       blk_out
);

    logic              valid_reg;
    blk_t              blk_reg;
    blk_t              blk_next;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] mix_a;
    logic [WORD_W-1:0] mix_b;
    logic              upd_a;

    assign sum   = (blk_in.kind == KIND_DECRYPT) ? cfg.dec_sum : cfg.enc_sum;
    assign mix_a = mix(blk_in.b, sum, key.k0, key.k1);
    assign mix_b = mix(blk_in.a, sum, key.k2, key.k3);
    // encrypt updates a then b; decrypt undoes b first, then a
    assign upd_a = cfg.odd ^ (blk_in.kind == KIND_ENCRYPT);

    always_comb
    begin
        blk_next = blk_in;
        if (upd_a)
        begin
            blk_next.a = (blk_in.kind == KIND_DECRYPT) ? blk_in.a - mix_a
                                                       : blk_in.a + mix_a;
        end
        else
        begin
            blk_next.b = (blk_in.kind == KIND_DECRYPT) ? blk_in.b - mix_b
                                                       : blk_in.b + mix_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            blk_reg <= blk_next;
        end
    end

    assign valid_out = valid_reg;
    assign blk_out   = blk_reg;

endmodule

@@ rtl/tea_wide_block_cipher_top.sv @@
// throughput: one block per cycle while out_stall does not hold the pipeline, one register stage per half-round
// the whole pipeline moves together; it holds while a result waits under out_stall
// reset clears all stage valid bits and the key registers to zero
// depends on tw_pkg, tw_key_regs, tw_half_round
module tea_wide_block_cipher_top
    import tw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [WORD_W-1:0]    in_word0,
    input  logic [WORD_W-1:0]    in_word1,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_W-1:0]    out_word0,
    output logic [WORD_W-1:0]    out_word1
);

    key_t key;
    logic advance;
    logic stage_valid [0:HALF_ROUNDS];
    blk_t stage_blk   [0:HALF_ROUNDS];

    assign cfg_ready = 1'b1;

    tw_key_regs u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    // the last stage is the output register
    assign advance  = !stage_valid[HALF_ROUNDS] || !out_stall;
    assign in_stall = !advance;

    assign stage_valid[0]    = in_valid;
    assign stage_blk[0].kind = kind;
    assign stage_blk[0].a    = in_word0;
    assign stage_blk[0].b    = in_word1;

    for (genvar i = 0; i < HALF_ROUNDS; i++)
    begin : g_stage
        tw_half_round u_half (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .cfg       (stage_cfg(i)),
            .key       (key),
            .valid_in  (stage_valid[i]),
            .blk_in    (stage_blk[i]),
            .valid_out (stage_valid[i+1]),
            .blk_out   (stage_blk[i+1])
        );
    end

    assign out_valid = stage_valid[HALF_ROUNDS];
    assign out_word0 = stage_blk[HALF_ROUNDS].a;
    assign out_word1 = stage_blk[HALF_ROUNDS].b;

endmodule
